@@ design/mesh_blob_stream_validator_macros.svh @@
// Assertion macros for the mesh blob stream validator checker.
// Depends on aclk and aresetn being visible where a macro is used.
`ifndef MESH_BLOB_STREAM_VALIDATOR_MACROS_SVH
`define MESH_BLOB_STREAM_VALIDATOR_MACROS_SVH

// Property that holds in the same cycle.
`define MBSV_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Property whose consequence holds in the next cycle.
`define MBSV_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/mbsv_pkg.sv @@
// Shared types and codes for the mesh blob stream validator.
// No dependencies; used by the top level and its checker.
package mbsv_pkg;

    localparam int MAX_MODELS_DEF = 256;

    localparam logic [5:0] HDR_BYTES  = 6'd12;
    localparam logic [5:0] VEC_BYTES  = 6'd8;
    localparam logic [5:0] PRIM_BYTES = 6'd48;
    localparam logic [31:0] TRI_MARK  = 32'hFFFF_FFFF;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_ACCEPTED  = 3'd1;
    localparam logic [2:0] ST_TRUNC     = 3'd2;
    localparam logic [2:0] ST_ORD_RANGE = 3'd3;
    localparam logic [2:0] ST_DUPLICATE = 3'd4;
    localparam logic [2:0] ST_OVERRUN   = 3'd5;
    localparam logic [2:0] ST_BAD_INDEX = 3'd6;

    localparam logic [2:0] KIND_PART = 3'd0;
    localparam logic [2:0] KIND_MESH = 3'd1;
    localparam logic [2:0] KIND_VERT = 3'd2;
    localparam logic [2:0] KIND_NORM = 3'd3;
    localparam logic [2:0] KIND_PRIM = 3'd4;
    localparam logic [2:0] KIND_NONE = 3'd5;

    localparam logic [1:0] REG_BLOB_LENGTH = 2'd0;
    localparam logic [1:0] REG_PART_COUNT  = 2'd1;
    localparam logic [1:0] REG_MODEL_COUNT = 2'd2;

    typedef enum logic [2:0] {
        PH_PART = 3'd0,
        PH_MESH = 3'd1,
        PH_VERT = 3'd2,
        PH_NORM = 3'd3,
        PH_PRIM = 3'd4,
        PH_DONE = 3'd5
    } phase_t;

    typedef struct packed {
        phase_t      phase;
        logic [31:0] parts_done;
        logic [31:0] mesh_cnt;
        logic [31:0] elem_cnt;
        logic        verdict;
    } parse_t;

    typedef struct packed {
        parse_t     s;
        logic [2:0] st;
        logic [2:0] kind;
    } res_t;

endpackage

@@ design/mesh_blob_stream_validator.sv @@
// Throughput: one byte per cycle unless a held result stalls s_ready; a single output
// register refills on the edge it drains and registers an accepted byte's result.
// All parse work for a byte is one pass of logic from the state registers to that register.
// Reset (aresetn low, synchronous) clears parse state, registers to their defaults,
// the seen-ordinal map and the output valid; a first_byte also clears the parse.
module mesh_blob_stream_validator #(
    parameter int MAX_MODELS = mbsv_pkg::MAX_MODELS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_first_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic [2:0]  m_element_kind,
    output logic [7:0]  m_part_ordinal,
    output logic [31:0] m_mesh_index,
    output logic [31:0] m_element_index,
    output logic [31:0] m_byte_offset,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int IDX_W = (MAX_MODELS > 1) ? $clog2(MAX_MODELS) : 1;
    localparam logic [8:0] MAX_M9 = 9'(MAX_MODELS);

    logic [31:0] blob_length_reg, part_count_reg;
    logic [8:0]  model_count_reg;

    mbsv_pkg::parse_t ps_reg, ps_next;
    logic [5:0]  rbc_reg, rbc_next;
    logic [31:0] fa_reg, fa_next;
    logic [31:0] cons_reg, cons_next;
    logic [31:0] mtot_reg, mtot_next;
    logic [31:0] vt_reg, vt_next;
    logic [31:0] nt_reg, nt_next;
    logic [31:0] pt_reg, pt_next;
    logic [7:0]  ord_reg, ord_next;
    logic        tri_reg, tri_next;
    logic [MAX_MODELS-1:0] seen_reg, seen_next;

    logic        m_valid_reg, m_valid_next;
    logic [2:0]  st_reg, st_next, kind_reg, kind_next;
    logic [7:0]  oord_reg, oord_next;
    logic [31:0] omesh_reg, omesh_next, oelem_reg, oelem_next, off_reg, off_next;

    logic accept;

    function automatic logic [31:0] rem_of(logic [31:0] blen, logic [31:0] cons);
        return (blen > cons) ? blen - cons : 32'd0;
    endfunction

    function automatic logic [31:0] sel_mesh(logic [2:0] kind, logic [31:0] v);
        return (kind >= mbsv_pkg::KIND_MESH && kind <= mbsv_pkg::KIND_PRIM) ? v : 32'd0;
    endfunction

    function automatic logic [31:0] sel_elem(logic [2:0] kind, logic [31:0] v);
        return (kind >= mbsv_pkg::KIND_VERT && kind <= mbsv_pkg::KIND_PRIM) ? v : 32'd0;
    endfunction

    // Walk through finished phases; the chain is at most five phases long.
    function automatic mbsv_pkg::res_t resolve(mbsv_pkg::parse_t s_in, logic [31:0] rem,
                                               logic [31:0] pcnt, logic [31:0] mtot,
                                               logic [31:0] vt, logic [31:0] nt,
                                               logic [31:0] pt);
        mbsv_pkg::res_t r;
        logic stop;
        logic [37:0] need;
        r.s = s_in;
        r.st = mbsv_pkg::ST_OK;
        r.kind = mbsv_pkg::KIND_NONE;
        stop = 1'b0;
        for (int i = 0; i < 6; i++) begin
            need = '0;
            if (!stop) begin
                case (r.s.phase)
                    mbsv_pkg::PH_PART: begin
                        stop = 1'b1;
                        if (r.s.parts_done >= pcnt) begin
                            r.kind = mbsv_pkg::KIND_NONE;
                            r.st = mbsv_pkg::ST_ACCEPTED;
                        end else if (rem < 32'(mbsv_pkg::HDR_BYTES)) begin
                            r.kind = mbsv_pkg::KIND_PART;
                            r.st = mbsv_pkg::ST_TRUNC;
                        end
                    end
                    mbsv_pkg::PH_MESH: begin
                        if (r.s.mesh_cnt >= mtot) begin
                            r.s.parts_done = r.s.parts_done + 32'd1;
                            r.s.mesh_cnt = '0;
                            r.s.phase = mbsv_pkg::PH_PART;
                        end else begin
                            stop = 1'b1;
                            if (rem < 32'(mbsv_pkg::HDR_BYTES)) begin
                                r.kind = mbsv_pkg::KIND_MESH;
                                r.st = mbsv_pkg::ST_TRUNC;
                            end
                        end
                    end
                    mbsv_pkg::PH_VERT: begin
                        if (r.s.elem_cnt < vt) begin
                            stop = 1'b1;
                        end else begin
                            r.s.elem_cnt = '0;
                            r.s.phase = mbsv_pkg::PH_NORM;
                            need = {3'b0, nt, 3'b0};
                            if (need > {6'b0, rem}) begin
                                r.kind = mbsv_pkg::KIND_NORM;
                                r.st = mbsv_pkg::ST_OVERRUN;
                                stop = 1'b1;
                            end
                        end
                    end
                    mbsv_pkg::PH_NORM: begin
                        if (r.s.elem_cnt < nt) begin
                            stop = 1'b1;
                        end else begin
                            r.s.elem_cnt = '0;
                            r.s.phase = mbsv_pkg::PH_PRIM;
                            // 48 * total as two shifted copies
                            need = {1'b0, pt, 5'b0} + {2'b0, pt, 4'b0};
                            if (need > {6'b0, rem}) begin
                                r.kind = mbsv_pkg::KIND_PRIM;
                                r.st = mbsv_pkg::ST_OVERRUN;
                                stop = 1'b1;
                            end
                        end
                    end
                    mbsv_pkg::PH_PRIM: begin
                        if (r.s.elem_cnt < pt) begin
                            stop = 1'b1;
                        end else begin
                            r.s.elem_cnt = '0;
                            r.s.mesh_cnt = r.s.mesh_cnt + 32'd1;
                            r.s.phase = mbsv_pkg::PH_MESH;
                        end
                    end
                    default: stop = 1'b1;
                endcase
            end
        end
        if (r.st != mbsv_pkg::ST_OK) begin
            r.s.verdict = 1'b1;
            r.s.phase = mbsv_pkg::PH_DONE;
        end
        return r;
    endfunction

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign pready  = 1'b1;

    always_comb begin
        case (paddr[3:2])
            mbsv_pkg::REG_BLOB_LENGTH: prdata = blob_length_reg;
            mbsv_pkg::REG_PART_COUNT:  prdata = part_count_reg;
            mbsv_pkg::REG_MODEL_COUNT: prdata = {23'b0, model_count_reg};
            default:                   prdata = 32'd0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            blob_length_reg <= '0;
            part_count_reg  <= '0;
            model_count_reg <= 9'd1;
        end else if (psel && penable && pwrite && pready) begin
            case (paddr[3:2])
                mbsv_pkg::REG_BLOB_LENGTH: blob_length_reg <= pwdata;
                mbsv_pkg::REG_PART_COUNT:  part_count_reg <= pwdata;
                mbsv_pkg::REG_MODEL_COUNT: model_count_reg <= pwdata[8:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        mbsv_pkg::parse_t ps;
        mbsv_pkg::res_t   r;
        logic [5:0]  rbc, rbc_n, rbc_m1;
        logic [31:0] fa, cons, off;
        logic [3:0]  w;
        logic        done_word, go, tail, bad;
        logic [8:0]  lim;

        ps_next = ps_reg;
        rbc_next = rbc_reg;
        fa_next = fa_reg;
        cons_next = cons_reg;
        mtot_next = mtot_reg;
        vt_next = vt_reg;
        nt_next = nt_reg;
        pt_next = pt_reg;
        ord_next = ord_reg;
        tri_next = tri_reg;
        seen_next = seen_reg;
        m_valid_next = m_valid_reg && !m_ready;
        st_next = st_reg;
        kind_next = kind_reg;
        oord_next = oord_reg;
        omesh_next = omesh_reg;
        oelem_next = oelem_reg;
        off_next = off_reg;

        ps = ps_reg;
        rbc = rbc_reg;
        fa = fa_reg;
        cons = cons_reg;
        r = '0;
        rbc_n = '0;
        rbc_m1 = '0;
        off = '0;
        w = '0;
        done_word = 1'b0;
        go = 1'b0;
        tail = 1'b0;
        bad = 1'b0;
        lim = (model_count_reg < MAX_M9) ? model_count_reg : MAX_M9;

        if (accept) begin
            m_valid_next = 1'b0;
            if (s_first_byte) begin
                ps.phase = mbsv_pkg::PH_PART;
                ps.parts_done = '0;
                ps.mesh_cnt = '0;
                ps.elem_cnt = '0;
                ps.verdict = 1'b0;
                rbc = '0;
                fa = '0;
                cons = '0;
                mtot_next = '0;
                vt_next = '0;
                nt_next = '0;
                pt_next = '0;
                ord_next = '0;
                tri_next = 1'b0;
                seen_next = '0;
            end

            if (!ps.verdict) begin
                off = cons;
                go = 1'b1;
                if (rbc == '0) begin
                    r = resolve(ps, rem_of(blob_length_reg, cons), part_count_reg,
                                mtot_next, vt_next, nt_next, pt_next);
                    ps = r.s;
                    if (r.st != mbsv_pkg::ST_OK) begin
                        go = 1'b0;
                        m_valid_next = 1'b1;
                        st_next = r.st;
                        kind_next = r.kind;
                        oord_next = ord_next;
                        omesh_next = sel_mesh(r.kind, ps.mesh_cnt);
                        oelem_next = sel_elem(r.kind, ps.elem_cnt);
                        off_next = off;
                    end
                end

                if (go) begin
                    // assemble little-endian words
                    if (rbc[1:0] == 2'd0) begin
                        fa = {24'b0, s_data_byte};
                    end else begin
                        fa = fa | (32'(s_data_byte) << {rbc[1:0], 3'b0});
                    end
                    cons = cons + 32'd1;
                    rbc_n = rbc + 6'd1;
                    rbc = rbc_n;
                    rbc_m1 = rbc_n - 6'd1;
                    w = rbc_m1[5:2];
                    done_word = (rbc_n[1:0] == 2'd0);
                    off_next = off;

                    case (ps.phase)
                        mbsv_pkg::PH_PART: begin
                            if (done_word && w == 4'd0) begin
                                ord_next = fa[7:0];
                                if (fa >= 32'(lim)) begin
                                    bad = 1'b1;
                                    st_next = mbsv_pkg::ST_ORD_RANGE;
                                end else if (seen_next[fa[IDX_W-1:0]]) begin
                                    bad = 1'b1;
                                    st_next = mbsv_pkg::ST_DUPLICATE;
                                end
                            end
                            if (bad) begin
                                ps.verdict = 1'b1;
                                ps.phase = mbsv_pkg::PH_DONE;
                                m_valid_next = 1'b1;
                                kind_next = mbsv_pkg::KIND_PART;
                                oord_next = ord_next;
                                omesh_next = '0;
                                oelem_next = '0;
                            end else if (rbc_n >= mbsv_pkg::HDR_BYTES) begin
                                mtot_next = fa;
                                if (fa != '0) begin
                                    seen_next[ord_next[IDX_W-1:0]] = 1'b1;
                                end
                                ps.mesh_cnt = '0;
                                rbc = '0;
                                m_valid_next = 1'b1;
                                st_next = mbsv_pkg::ST_OK;
                                kind_next = mbsv_pkg::KIND_PART;
                                oord_next = ord_next;
                                omesh_next = '0;
                                oelem_next = '0;
                                ps.phase = mbsv_pkg::PH_MESH;
                                tail = 1'b1;
                            end
                        end
                        mbsv_pkg::PH_MESH: begin
                            if (done_word) begin
                                case (w)
                                    4'd0:    vt_next = fa;
                                    4'd1:    nt_next = fa;
                                    default: pt_next = fa;
                                endcase
                            end
                            if (rbc_n >= mbsv_pkg::HDR_BYTES) begin
                                rbc = '0;
                                m_valid_next = 1'b1;
                                st_next = mbsv_pkg::ST_OK;
                                kind_next = mbsv_pkg::KIND_MESH;
                                oord_next = ord_next;
                                omesh_next = ps.mesh_cnt;
                                oelem_next = '0;
                                ps.elem_cnt = '0;
                                ps.phase = mbsv_pkg::PH_VERT;
                                if ({3'b0, vt_next, 3'b0} >
                                    {6'b0, rem_of(blob_length_reg, cons)}) begin
                                    ps.verdict = 1'b1;
                                    ps.phase = mbsv_pkg::PH_DONE;
                                    st_next = mbsv_pkg::ST_OVERRUN;
                                    kind_next = mbsv_pkg::KIND_VERT;
                                end else begin
                                    tail = 1'b1;
                                end
                            end
                        end
                        mbsv_pkg::PH_VERT, mbsv_pkg::PH_NORM: begin
                            if (rbc_n >= mbsv_pkg::VEC_BYTES) begin
                                rbc = '0;
                                m_valid_next = 1'b1;
                                st_next = mbsv_pkg::ST_OK;
                                kind_next = 3'(ps.phase);
                                oord_next = ord_next;
                                omesh_next = ps.mesh_cnt;
                                oelem_next = ps.elem_cnt;
                                ps.elem_cnt = ps.elem_cnt + 32'd1;
                                tail = 1'b1;
                            end
                        end
                        mbsv_pkg::PH_PRIM: begin
                            if (done_word && w < 4'd8) begin
                                if (w < 4'd3) begin
                                    bad = fa >= vt_next;
                                end else if (w == 4'd3) begin
                                    tri_next = (fa == mbsv_pkg::TRI_MARK);
                                    bad = (fa != mbsv_pkg::TRI_MARK) && (fa >= vt_next);
                                end else if (w < 4'd7 || !tri_next) begin
                                    bad = fa >= nt_next;
                                end
                            end
                            if (bad) begin
                                ps.verdict = 1'b1;
                                ps.phase = mbsv_pkg::PH_DONE;
                                m_valid_next = 1'b1;
                                st_next = mbsv_pkg::ST_BAD_INDEX;
                                kind_next = mbsv_pkg::KIND_PRIM;
                                oord_next = ord_next;
                                omesh_next = ps.mesh_cnt;
                                oelem_next = ps.elem_cnt;
                            end else if (rbc_n >= mbsv_pkg::PRIM_BYTES) begin
                                rbc = '0;
                                m_valid_next = 1'b1;
                                st_next = mbsv_pkg::ST_OK;
                                kind_next = mbsv_pkg::KIND_PRIM;
                                oord_next = ord_next;
                                omesh_next = ps.mesh_cnt;
                                oelem_next = ps.elem_cnt;
                                ps.elem_cnt = ps.elem_cnt + 32'd1;
                                tail = 1'b1;
                            end
                        end
                        default: ;
                    endcase

                    if (tail) begin
                        r = resolve(ps, rem_of(blob_length_reg, cons), part_count_reg,
                                    mtot_next, vt_next, nt_next, pt_next);
                        ps = r.s;
                        // a verdict on the completing byte replaces the element result
                        if (r.st != mbsv_pkg::ST_OK) begin
                            st_next = r.st;
                            kind_next = r.kind;
                            omesh_next = sel_mesh(r.kind, ps.mesh_cnt);
                            oelem_next = sel_elem(r.kind, ps.elem_cnt);
                        end
                    end
                end
            end

            ps_next = ps;
            rbc_next = rbc;
            fa_next = fa;
            cons_next = cons;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ps_reg <= '{phase: mbsv_pkg::PH_PART, parts_done: '0, mesh_cnt: '0,
                        elem_cnt: '0, verdict: 1'b0};
            rbc_reg <= '0;
            fa_reg <= '0;
            cons_reg <= '0;
            mtot_reg <= '0;
            vt_reg <= '0;
            nt_reg <= '0;
            pt_reg <= '0;
            ord_reg <= '0;
            tri_reg <= 1'b0;
            seen_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            ps_reg <= ps_next;
            rbc_reg <= rbc_next;
            fa_reg <= fa_next;
            cons_reg <= cons_next;
            mtot_reg <= mtot_next;
            vt_reg <= vt_next;
            nt_reg <= nt_next;
            pt_reg <= pt_next;
            ord_reg <= ord_next;
            tri_reg <= tri_next;
            seen_reg <= seen_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        st_reg <= st_next;
        kind_reg <= kind_next;
        oord_reg <= oord_next;
        omesh_reg <= omesh_next;
        oelem_reg <= oelem_next;
        off_reg <= off_next;
    end

    assign m_valid = m_valid_reg;
    assign m_status = st_reg;
    assign m_element_kind = kind_reg;
    assign m_part_ordinal = oord_reg;
    assign m_mesh_index = omesh_reg;
    assign m_element_index = oelem_reg;
    assign m_byte_offset = off_reg;

endmodule

@@ design/mbsv_checker.sv @@
// Port-level assertions for the mesh blob stream validator, bound to the top level.
// Depends on mbsv_pkg and mesh_blob_stream_validator_macros.svh.
`include "mesh_blob_stream_validator_macros.svh"

module mbsv_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [2:0]  m_status,
    input logic [2:0]  m_element_kind,
    input logic [31:0] m_mesh_index,
    input logic [31:0] m_element_index,
    input logic [31:0] m_byte_offset
);

    `MBSV_ASSERT_NEXT(a_hold, m_valid && !m_ready, m_valid && $stable(m_status) && $stable(m_byte_offset), "result transaction changed while stalled")
    `MBSV_ASSERT_NOW(a_ready_free, !m_valid, s_ready, "input stalled with empty output")
    `MBSV_ASSERT_NOW(a_ok_kind, m_valid && m_status == mbsv_pkg::ST_OK, m_element_kind != mbsv_pkg::KIND_NONE, "element result without element kind")
    `MBSV_ASSERT_NOW(a_accept_none, m_valid && m_status == mbsv_pkg::ST_ACCEPTED, m_element_kind == mbsv_pkg::KIND_NONE && m_mesh_index == 32'd0 && m_element_index == 32'd0, "accepted verdict carries an element")
    `MBSV_ASSERT_NOW(a_part_idx, m_valid && m_element_kind == mbsv_pkg::KIND_PART, m_mesh_index == 32'd0 && m_element_index == 32'd0, "part header with nonzero indices")

endmodule

bind mesh_blob_stream_validator mbsv_checker u_mbsv_checker (.*);

@@ tb/mesh_blob_stream_validator_test.sv @@
// Testbench for mesh_blob_stream_validator: random well-formed and damaged geometry blobs
// with random stalls on both channels, checked against an in-bench parse predictor.
// Depends on mbsv_pkg and the mesh_blob_stream_validator top level.
`timescale 1ns / 100ps

typedef struct {
    logic [2:0]  st;
    logic [2:0]  kind;
    logic [7:0]  ord;
    logic [31:0] mesh;
    logic [31:0] elem;
    logic [31:0] off;
} blob_event_t;

class blob_parse_scoreboard;
    logic [31:0] cfg_len;
    logic [31:0] cfg_parts;
    logic [8:0]  cfg_models;

    mbsv_pkg::phase_t phase;
    logic [5:0]  rec_bytes;
    logic [31:0] word_acc;
    logic [31:0] consumed;
    logic [31:0] parts_done;
    logic [31:0] mesh_total;
    logic [31:0] mesh_cnt;
    logic [31:0] vert_total;
    logic [31:0] norm_total;
    logic [31:0] prim_total;
    logic [31:0] elem_cnt;
    logic [7:0]  ordinal;
    bit          seen[256];
    bit          finished;
    bit          triangle;

    blob_event_t pending[$];
    int          errors;
    int          checked;
    int          verdicts;

    function new();
        cfg_len = 0;
        cfg_parts = 0;
        cfg_models = 1;
        errors = 0;
        checked = 0;
        verdicts = 0;
        restart();
    endfunction

    function void restart();
        phase = mbsv_pkg::PH_PART;
        rec_bytes = 0;
        word_acc = 0;
        consumed = 0;
        parts_done = 0;
        mesh_total = 0;
        mesh_cnt = 0;
        vert_total = 0;
        norm_total = 0;
        prim_total = 0;
        elem_cnt = 0;
        ordinal = 0;
        foreach (seen[i]) seen[i] = 0;
        finished = 0;
        triangle = 0;
    endfunction

    function logic [31:0] bytes_left();
        return (cfg_len > consumed) ? cfg_len - consumed : 32'd0;
    endfunction

    function logic [2:0] give(logic [2:0] st);
        finished = 1;
        phase = mbsv_pkg::PH_DONE;
        return st;
    endfunction

    function void fill(output blob_event_t r, input logic [2:0] st, input logic [2:0] kind,
                       input logic [31:0] off);
        r.st = st;
        r.kind = kind;
        r.ord = ordinal;
        r.mesh = (kind >= mbsv_pkg::KIND_MESH && kind <= mbsv_pkg::KIND_PRIM) ?
                 mesh_cnt : 32'd0;
        r.elem = (kind >= mbsv_pkg::KIND_VERT && kind <= mbsv_pkg::KIND_PRIM) ?
                 elem_cnt : 32'd0;
        r.off = off;
    endfunction

    function logic [2:0] open_array(mbsv_pkg::phase_t ph, logic [31:0] total,
                                    logic [31:0] size, output logic [2:0] kind);
        elem_cnt = 0;
        phase = ph;
        if (total > bytes_left() / size) begin
            kind = 3'(ph);
            return give(mbsv_pkg::ST_OVERRUN);
        end
        return mbsv_pkg::ST_OK;
    endfunction

    // Walk past finished arrays, meshes and parts; nonzero return is a verdict.
    function logic [2:0] settle(output logic [2:0] kind);
        logic [2:0] v;
        kind = mbsv_pkg::KIND_NONE;
        while (1) begin
            case (phase)
                mbsv_pkg::PH_PART: begin
                    if (parts_done >= cfg_parts) begin
                        kind = mbsv_pkg::KIND_NONE;
                        return give(mbsv_pkg::ST_ACCEPTED);
                    end
                    if (bytes_left() < 32'(mbsv_pkg::HDR_BYTES)) begin
                        kind = mbsv_pkg::KIND_PART;
                        return give(mbsv_pkg::ST_TRUNC);
                    end
                    return mbsv_pkg::ST_OK;
                end
                mbsv_pkg::PH_MESH: begin
                    if (mesh_cnt >= mesh_total) begin
                        parts_done++;
                        mesh_cnt = 0;
                        phase = mbsv_pkg::PH_PART;
                    end else if (bytes_left() < 32'(mbsv_pkg::HDR_BYTES)) begin
                        kind = mbsv_pkg::KIND_MESH;
                        return give(mbsv_pkg::ST_TRUNC);
                    end else begin
                        return mbsv_pkg::ST_OK;
                    end
                end
                mbsv_pkg::PH_VERT: begin
                    if (elem_cnt < vert_total) return mbsv_pkg::ST_OK;
                    v = open_array(mbsv_pkg::PH_NORM, norm_total,
                                   32'(mbsv_pkg::VEC_BYTES), kind);
                    if (v != mbsv_pkg::ST_OK) return v;
                end
                mbsv_pkg::PH_NORM: begin
                    if (elem_cnt < norm_total) return mbsv_pkg::ST_OK;
                    v = open_array(mbsv_pkg::PH_PRIM, prim_total,
                                   32'(mbsv_pkg::PRIM_BYTES), kind);
                    if (v != mbsv_pkg::ST_OK) return v;
                end
                mbsv_pkg::PH_PRIM: begin
                    if (elem_cnt < prim_total) return mbsv_pkg::ST_OK;
                    elem_cnt = 0;
                    mesh_cnt++;
                    phase = mbsv_pkg::PH_MESH;
                end
                default: return mbsv_pkg::ST_OK;
            endcase
        end
        return mbsv_pkg::ST_OK;
    endfunction

    function bit parse_byte(logic [7:0] b, logic f, output blob_event_t r);
        logic [31:0] off;
        logic [31:0] lim;
        logic [2:0]  kind;
        logic [2:0]  v;
        logic [3:0]  w;
        bit          word_done;
        bit          bad;
        if (f) restart();
        if (finished) return 0;
        off = consumed;
        if (rec_bytes == 0) begin
            v = settle(kind);
            if (v != mbsv_pkg::ST_OK) begin
                fill(r, v, kind, off);
                return 1;
            end
        end
        if (rec_bytes[1:0] == 0) word_acc = {24'd0, b};
        else word_acc |= {24'd0, b} << (8 * rec_bytes[1:0]);
        consumed++;
        rec_bytes++;
        word_done = (rec_bytes[1:0] == 0);
        w = 4'((rec_bytes - 6'd1) >> 2);
        case (phase)
            mbsv_pkg::PH_PART: begin
                lim = (cfg_models < 9'd256) ? 32'(cfg_models) : 32'd256;
                if (word_done && w == 0) begin
                    ordinal = word_acc[7:0];
                    if (word_acc >= lim) begin
                        fill(r, give(mbsv_pkg::ST_ORD_RANGE), mbsv_pkg::KIND_PART, off);
                        return 1;
                    end
                    if (seen[ordinal]) begin
                        fill(r, give(mbsv_pkg::ST_DUPLICATE), mbsv_pkg::KIND_PART, off);
                        return 1;
                    end
                end
                if (rec_bytes < mbsv_pkg::HDR_BYTES) return 0;
                mesh_total = word_acc;
                if (mesh_total > 0) seen[ordinal] = 1;
                mesh_cnt = 0;
                rec_bytes = 0;
                fill(r, mbsv_pkg::ST_OK, mbsv_pkg::KIND_PART, off);
                phase = mbsv_pkg::PH_MESH;
            end
            mbsv_pkg::PH_MESH: begin
                if (word_done) begin
                    if (w == 0) vert_total = word_acc;
                    else if (w == 1) norm_total = word_acc;
                    else prim_total = word_acc;
                end
                if (rec_bytes < mbsv_pkg::HDR_BYTES) return 0;
                rec_bytes = 0;
                fill(r, mbsv_pkg::ST_OK, mbsv_pkg::KIND_MESH, off);
                v = open_array(mbsv_pkg::PH_VERT, vert_total, 32'(mbsv_pkg::VEC_BYTES), kind);
                if (v != mbsv_pkg::ST_OK) begin
                    fill(r, v, kind, off);
                    return 1;
                end
            end
            mbsv_pkg::PH_VERT, mbsv_pkg::PH_NORM: begin
                if (rec_bytes < mbsv_pkg::VEC_BYTES) return 0;
                rec_bytes = 0;
                fill(r, mbsv_pkg::ST_OK, 3'(phase), off);
                elem_cnt++;
            end
            mbsv_pkg::PH_PRIM: begin
                if (word_done && w < 8) begin
                    bad = 0;
                    if (w < 3) begin
                        bad = word_acc >= vert_total;
                    end else if (w == 3) begin
                        triangle = (word_acc == mbsv_pkg::TRI_MARK);
                        bad = !triangle && word_acc >= vert_total;
                    end else if (w < 7 || !triangle) begin
                        bad = word_acc >= norm_total;
                    end
                    if (bad) begin
                        fill(r, give(mbsv_pkg::ST_BAD_INDEX), mbsv_pkg::KIND_PRIM, off);
                        return 1;
                    end
                end
                if (rec_bytes < mbsv_pkg::PRIM_BYTES) return 0;
                rec_bytes = 0;
                fill(r, mbsv_pkg::ST_OK, mbsv_pkg::KIND_PRIM, off);
                elem_cnt++;
            end
            default: return 0;
        endcase
        v = settle(kind);
        if (v != mbsv_pkg::ST_OK) fill(r, v, kind, off);
        return 1;
    endfunction

    function void note_byte(logic [7:0] b, logic f);
        blob_event_t r;
        if (parse_byte(b, f, r)) pending.push_back(r);
    endfunction

    task report_mismatch(string what);
        errors++;
        $display("MISMATCH at %0t: %s", $time, what);
    endtask

    task check_event(blob_event_t got);
        blob_event_t exp;
        if (pending.size() == 0) begin
            report_mismatch($sformatf("unexpected result status %0d kind %0d off %0d",
                                      got.st, got.kind, got.off));
            return;
        end
        exp = pending.pop_front();
        checked++;
        if (exp.st != mbsv_pkg::ST_OK) verdicts++;
        if (got.st != exp.st) report_mismatch($sformatf("status %0d, want %0d (off %0d)",
                                                        got.st, exp.st, exp.off));
        if (got.kind != exp.kind) report_mismatch($sformatf("kind %0d, want %0d (off %0d)",
                                                            got.kind, exp.kind, exp.off));
        if (got.ord != exp.ord) report_mismatch($sformatf("ordinal %0d, want %0d (off %0d)",
                                                          got.ord, exp.ord, exp.off));
        if (got.mesh != exp.mesh) report_mismatch($sformatf("mesh %0d, want %0d (off %0d)",
                                                            got.mesh, exp.mesh, exp.off));
        if (got.elem != exp.elem) report_mismatch($sformatf("element %0d, want %0d (off %0d)",
                                                            got.elem, exp.elem, exp.off));
        if (got.off != exp.off) report_mismatch($sformatf("offset %0d, want %0d",
                                                          got.off, exp.off));
    endtask
endclass

module mesh_blob_stream_validator_test;
    localparam int CYCLE_LIMIT = 400000;
    localparam int ITEM_TARGET = 1850;

    localparam int FAULT_NONE    = 0;
    localparam int FAULT_RANGE   = 1;
    localparam int FAULT_DUP     = 2;
    localparam int FAULT_INDEX   = 3;
    localparam int FAULT_OVERRUN = 4;
    localparam int FAULT_TRUNC   = 5;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_data_byte;
    logic        s_first_byte;
    logic        m_valid;
    logic        m_ready;
    logic [2:0]  m_status;
    logic [2:0]  m_element_kind;
    logic [7:0]  m_part_ordinal;
    logic [31:0] m_mesh_index;
    logic [31:0] m_element_index;
    logic [31:0] m_byte_offset;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    blob_parse_scoreboard sb;
    logic [7:0] blob_q[$];
    int         bytes_sent;
    int         blobs_sent;
    int         cycles;
    bit         calm;

    mesh_blob_stream_validator u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data_byte(s_data_byte),
        .s_first_byte(s_first_byte),
        .m_valid(m_valid), .m_ready(m_ready), .m_status(m_status),
        .m_element_kind(m_element_kind), .m_part_ordinal(m_part_ordinal),
        .m_mesh_index(m_mesh_index), .m_element_index(m_element_index),
        .m_byte_offset(m_byte_offset),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    // Note accepted bytes and check results on the same edge.
    always @(posedge aclk) begin
        blob_event_t got;
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("mesh_blob_stream_validator regression: fail");
            $finish;
        end
        if (aresetn && s_valid && s_ready) sb.note_byte(s_data_byte, s_first_byte);
        if (aresetn && m_valid && m_ready) begin
            got.st = m_status;
            got.kind = m_element_kind;
            got.ord = m_part_ordinal;
            got.mesh = m_mesh_index;
            got.elem = m_element_index;
            got.off = m_byte_offset;
            sb.check_event(got);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) m_ready <= 1'b0;
        else m_ready <= calm || ($urandom_range(0, 99) >= 36);
    end

    task apb_write(logic [1:0] idx, logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            mbsv_pkg::REG_BLOB_LENGTH: sb.cfg_len = value;
            mbsv_pkg::REG_PART_COUNT:  sb.cfg_parts = value;
            default:                   sb.cfg_models = value[8:0];
        endcase
    endtask

    task send_byte(logic [7:0] b, logic f);
        if (!calm && $urandom_range(0, 99) < 36) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data_byte <= b;
        s_first_byte <= f;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        bytes_sent++;
        calm = (bytes_sent >= 700 && bytes_sent < 1000);
    endtask

    // Let everything drain before touching the registers.
    task drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task push_word(logic [31:0] v);
        for (int i = 0; i < 4; i++) blob_q.push_back(v[8 * i +: 8]);
    endtask

    task push_random(int n);
        for (int i = 0; i < n; i++) blob_q.push_back(8'($urandom));
    endtask

    function logic [31:0] index_below(logic [31:0] n);
        return (n == 0) ? 32'd0 : 32'($urandom_range(0, n - 1));
    endfunction

    task build_blob(int nparts, int lim, int fault);
        int nmesh;
        int nv;
        int nn;
        int np;
        int base;
        int bad_part;
        logic [31:0] word;
        blob_q.delete();
        base = $urandom_range(0, 255);
        bad_part = nparts - 1;
        for (int p = 0; p < nparts; p++) begin
            if (fault == FAULT_RANGE && p == bad_part)
                word = (lim + $urandom_range(0, 3)) | ($urandom_range(0, 1) ? $urandom : 0);
            else if (fault == FAULT_DUP && p == bad_part && p > 0)
                word = base % lim;
            else
                word = (base + p) % lim;
            push_word(word);
            push_random(4);
            nmesh = $urandom_range(0, 2);
            if (fault == FAULT_DUP && p == 0) nmesh = 1;
            push_word(nmesh);
            for (int m = 0; m < nmesh; m++) begin
                nv = $urandom_range(0, 4);
                nn = $urandom_range(0, 3);
                np = (nv == 0) ? 0 : $urandom_range(0, 2);
                if (fault == FAULT_INDEX && nv == 0) begin
                    nv = 1;
                    np = 1;
                end
                push_word(nv);
                push_word(nn);
                push_word(np);
                push_random(8 * (nv + nn));
                for (int k = 0; k < np; k++) begin
                    bit tri_prim;
                    int bad_word;
                    tri_prim = ($urandom_range(0, 3) == 0);
                    bad_word = (fault == FAULT_INDEX) ? $urandom_range(0, 7) : 8;
                    for (int c = 0; c < 8; c++) begin
                        if (c == bad_word) word = (c < 4 ? nv : nn) + $urandom_range(0, 9);
                        else if (c == 3 && tri_prim) word = mbsv_pkg::TRI_MARK;
                        else if (c == 7 && tri_prim) word = $urandom;
                        else if (c < 4) word = index_below(nv);
                        else word = (nn == 0) ? $urandom : index_below(nn);
                        push_word(word);
                    end
                    push_random(16);
                end
            end
        end
    endtask

    task run_blob(int nparts, int models, int fault);
        int lim;
        int len;
        lim = (models == 0) ? 256 : ((models > 256) ? 256 : models);
        build_blob(nparts, lim, fault);
        len = blob_q.size();
        drain();
        if (fault == FAULT_OVERRUN && len > 0) len = len - $urandom_range(1, len < 20 ? len : 20);
        if ($urandom_range(0, 9) == 0 && fault == FAULT_NONE)
            apb_write(mbsv_pkg::REG_BLOB_LENGTH, '1);
        else
            apb_write(mbsv_pkg::REG_BLOB_LENGTH, len);
        if (fault == FAULT_TRUNC)
            apb_write(mbsv_pkg::REG_PART_COUNT, nparts + $urandom_range(1, 2));
        else
            apb_write(mbsv_pkg::REG_PART_COUNT, nparts);
        apb_write(mbsv_pkg::REG_MODEL_COUNT, models);
        push_random($urandom_range(0, 5));
        for (int i = 0; i < blob_q.size(); i++) begin
            // A rare restart mid-blob or stray start mark.
            if (i > 0 && $urandom_range(0, 199) == 0) send_byte(8'($urandom), 1'b1);
            send_byte(blob_q[i], i == 0);
        end
        blobs_sent++;
    endtask

    initial begin
        int fault;
        int models;
        sb = new();
        bytes_sent = 0;
        blobs_sent = 0;
        calm = 0;
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_data_byte <= 8'd0;
        s_first_byte <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Empty part list, header that cannot fit, and a model count of zero.
        apb_write(mbsv_pkg::REG_PART_COUNT, 32'd0);
        apb_write(mbsv_pkg::REG_BLOB_LENGTH, 32'd0);
        for (int i = 0; i < 3; i++) send_byte(8'hFF, i == 0);
        drain();
        apb_write(mbsv_pkg::REG_PART_COUNT, 32'd1);
        apb_write(mbsv_pkg::REG_BLOB_LENGTH, 32'd5);
        for (int i = 0; i < 5; i++) send_byte(8'h00, i == 0);
        drain();
        apb_write(mbsv_pkg::REG_BLOB_LENGTH, 32'd12);
        apb_write(mbsv_pkg::REG_MODEL_COUNT, 32'd0);
        for (int i = 0; i < 4; i++) send_byte(8'h00, i == 0);
        send_byte(8'h55, 1'b0);

        // Each fault once, then random blobs with mostly good structure.
        for (int f = FAULT_NONE; f <= FAULT_TRUNC; f++) run_blob(2, 4, f);
        run_blob(1, 511, FAULT_NONE);
        while (bytes_sent < ITEM_TARGET) begin
            fault = ($urandom_range(0, 9) < 6) ? FAULT_NONE : $urandom_range(1, 5);
            case ($urandom_range(0, 7))
                0:       models = 256;
                1:       models = 511;
                2:       models = 1;
                default: models = $urandom_range(2, 255);
            endcase
            run_blob($urandom_range(1, 4), models, fault);
            if ($urandom_range(0, 19) == 0) begin
                for (int i = 0; i < 10; i++)
                    send_byte(8'($urandom), $urandom_range(0, 7) == 0);
            end
        end

        drain();
        repeat (10) @(posedge aclk);
        $display("Sent %0d bytes in %0d blobs; checked %0d results, %0d of them verdicts.",
                 bytes_sent, blobs_sent, sb.checked, sb.verdicts);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("mesh_blob_stream_validator regression: pass");
        end else begin
            $display("%0d mismatches, %0d results never seen", sb.errors, sb.pending.size());
            $display("mesh_blob_stream_validator regression: fail");
        end
        $finish;
    end
endmodule

@@ mesh_blob_stream_validator.f @@
+incdir+design
design/mbsv_pkg.sv
design/mesh_blob_stream_validator.sv
design/mbsv_checker.sv
tb/mesh_blob_stream_validator_test.sv
